FILE: rtl/core/qbdp_pkg.sv
package qbdp_pkg;

    localparam int QUEUE_DEPTH = 2;
    localparam int QUEUE_AW    = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QUEUE_CW    = $clog2(QUEUE_DEPTH + 1);

    localparam logic        FMT_NIBBLE  = 1'b0;
    localparam logic [15:0] HALF_QNAN   = 16'h7E00;
    localparam logic [31:0] SINGLE_QNAN = 32'h7FC0_0000;

    // unpacked half: value = mant * 2^(exp - 25)
    typedef struct packed {
        logic        sign;
        logic        zero;
        logic        inf;
        logic        nan;
        logic [4:0]  exp;
        logic [10:0] mant;
    } half_t;

    typedef struct packed {
        half_t      act1;
        half_t      act2;
        half_t      scale;
        logic       w1_neg;
        logic [7:0] w1_mag;
        logic       w2_neg;
        logic [7:0] w2_mag;
        logic       two_terms;
        logic       last;
    } item_t;

    typedef enum logic [2:0] {
        BK_IDLE,
        BK_MUL1,
        BK_MUL2,
        BK_TERM,
        BK_ALIGN,
        BK_ADD,
        BK_NORM,
        BK_EMIT
    } bk_state_t;

    function automatic half_t unpack_half(input logic [15:0] h);
        half_t u;
        u.sign = h[15];
        u.zero = (h[14:10] == 5'd0) && (h[9:0] == 10'd0);
        u.inf  = (h[14:10] == 5'h1F) && (h[9:0] == 10'd0);
        u.nan  = (h[14:10] == 5'h1F) && (h[9:0] != 10'd0);
        u.exp  = (h[14:10] == 5'd0) ? 5'd1 : h[14:10];
        u.mant = {(h[14:10] != 5'd0), h[9:0]};
        return u;
    endfunction

    // leading zeros of a 29-bit word
    function automatic logic [4:0] lzc29(input logic [28:0] v);
        logic [4:0] n;
        n = 5'd29;
        for (int i = 0; i < 29; i++) begin
            if (v[i]) n = 5'(28 - i);
        end
        return n;
    endfunction

    // single to half, round to nearest even
    function automatic logic [15:0] to_half(input logic [31:0] b);
        logic              sg;
        logic [7:0]        ex;
        logic [22:0]       man;
        logic signed [9:0] e;
        logic [14:0]       r;
        logic [12:0]       rem;
        logic [23:0]       full;
        logic [4:0]        sh;
        logic [23:0]       rr;
        logic [23:0]       rm;
        logic [23:0]       hw;
        logic [15:0]       res;
        sg  = b[31];
        ex  = b[30:23];
        man = b[22:0];
        e   = $signed({2'b00, ex}) - 10'sd127;
        r   = '0;
        rem = '0;
        full = {1'b1, man};
        sh  = '0;
        rr  = '0;
        rm  = '0;
        hw  = '0;
        if (ex == 8'hFF) begin
            res = (man != 23'd0) ? HALF_QNAN : {sg, 15'h7C00};
        end else if (e > 10'sd15) begin
            res = {sg, 15'h7C00};
        end else if (e >= -10'sd14) begin
            r   = {5'(e + 10'sd15), man[22:13]};
            rem = man[12:0];
            if (rem > 13'h1000 || (rem == 13'h1000 && r[0])) r = r + 15'd1;
            res = {sg, r};
        end else if (e < -10'sd25) begin
            res = {sg, 15'd0};
        end else begin
            sh = 5'(-(e + 10'sd1));
            rr = full >> sh;
            rm = full & ((24'd1 << sh) - 24'd1);
            hw = 24'd1 << (sh - 5'd1);
            if (rm > hw || (rm == hw && rr[0])) rr = rr + 24'd1;
            res = {sg, rr[14:0]};
        end
        return res;
    endfunction

endpackage

FILE: rtl/core/qbdp_front.sv
module qbdp_front (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            cfg_valid,
    output logic            cfg_ready,
    input  logic            cfg_weight_format,
    input  logic            s_valid,
    output logic            s_ready,
    input  logic [15:0]     s_act_first,
    input  logic [15:0]     s_act_second,
    input  logic [7:0]      s_weight_code,
    input  logic [15:0]     s_block_scale,
    input  logic            s_end_of_dot,
    output logic            push_valid,
    input  logic            push_ready,
    output qbdp_pkg::item_t push_item
);

    logic fmt_reg;
    logic fmt_next;

    logic [3:0] nib_lo;
    logic [3:0] nib_hi;

    assign cfg_ready = 1'b1;
    assign fmt_next  = (cfg_valid && cfg_ready) ? cfg_weight_format : fmt_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fmt_reg <= qbdp_pkg::FMT_NIBBLE;
        end else begin
            fmt_reg <= fmt_next;
        end
    end

    assign s_ready    = push_ready;
    assign push_valid = s_valid;
    assign nib_lo     = s_weight_code[3:0];
    assign nib_hi     = s_weight_code[7:4];

    always_comb begin
        push_item.act1  = qbdp_pkg::unpack_half(s_act_first);
        push_item.act2  = qbdp_pkg::unpack_half(s_act_second);
        push_item.scale = qbdp_pkg::unpack_half(s_block_scale);
        push_item.last  = s_end_of_dot;
        if (fmt_reg == qbdp_pkg::FMT_NIBBLE) begin
            // nibble minus 8 as sign and magnitude
            push_item.w1_neg    = ~nib_lo[3];
            push_item.w1_mag    = {4'd0, nib_lo[3] ? (nib_lo - 4'd8) : (4'd8 - nib_lo)};
            push_item.w2_neg    = ~nib_hi[3];
            push_item.w2_mag    = {4'd0, nib_hi[3] ? (nib_hi - 4'd8) : (4'd8 - nib_hi)};
            push_item.two_terms = 1'b1;
        end else begin
            push_item.w1_neg    = s_weight_code[7];
            push_item.w1_mag    = s_weight_code[7] ? (~s_weight_code + 8'd1) : s_weight_code;
            push_item.w2_neg    = 1'b0;
            push_item.w2_mag    = 8'd0;
            push_item.two_terms = 1'b0;
        end
    end

endmodule

FILE: rtl/core/qbdp_fifo.sv
module qbdp_fifo (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            push_valid,
    output logic            push_ready,
    input  qbdp_pkg::item_t push_item,
    output logic            pop_valid,
    input  logic            pop_ready,
    output qbdp_pkg::item_t pop_item
);

    qbdp_pkg::item_t mem_reg [qbdp_pkg::QUEUE_DEPTH];

    logic [qbdp_pkg::QUEUE_AW-1:0] wr_ptr_reg;
    logic [qbdp_pkg::QUEUE_AW-1:0] wr_ptr_next;
    logic [qbdp_pkg::QUEUE_AW-1:0] rd_ptr_reg;
    logic [qbdp_pkg::QUEUE_AW-1:0] rd_ptr_next;
    logic [qbdp_pkg::QUEUE_CW-1:0] count_reg;
    logic [qbdp_pkg::QUEUE_CW-1:0] count_next;

    logic do_push;
    logic do_pop;

    assign push_ready = (count_reg != qbdp_pkg::QUEUE_CW'(qbdp_pkg::QUEUE_DEPTH));
    assign pop_valid  = (count_reg != '0);
    assign pop_item   = mem_reg[rd_ptr_reg];
    assign do_push    = push_valid && push_ready;
    assign do_pop     = pop_valid && pop_ready;

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (do_push) begin
            wr_ptr_next = (wr_ptr_reg == qbdp_pkg::QUEUE_AW'(qbdp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : wr_ptr_reg + 1'b1;
        end
        if (do_pop) begin
            rd_ptr_next = (rd_ptr_reg == qbdp_pkg::QUEUE_AW'(qbdp_pkg::QUEUE_DEPTH - 1))
                        ? '0 : rd_ptr_reg + 1'b1;
        end
        if (do_push && !do_pop) count_next = count_reg + 1'b1;
        if (!do_push && do_pop) count_next = count_reg - 1'b1;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_push) mem_reg[wr_ptr_reg] <= push_item;
    end

endmodule

FILE: rtl/core/qbdp_back.sv
module qbdp_back (
    input  logic            aclk,
    input  logic            aresetn,
    input  logic            q_valid,
    output logic            q_ready,
    input  qbdp_pkg::item_t q_item,
    output logic            m_valid,
    input  logic            m_ready,
    output logic [15:0]     m_dot_result
);

    qbdp_pkg::bk_state_t state_reg, state_next;
    qbdp_pkg::item_t     item_reg, item_next;
    logic                term_sel_reg, term_sel_next;
    logic [21:0]         p1_reg, p1_next;
    logic [28:0]         mterm_reg, mterm_next;
    logic                t_sign_reg, t_sign_next;
    logic [7:0]          t_exp_reg, t_exp_next;
    logic [23:0]         t_mant_reg, t_mant_next;
    logic                t_zero_reg, t_zero_next;
    logic                t_inf_reg, t_inf_next;
    logic                t_nan_reg, t_nan_next;
    logic [26:0]         big_reg, big_next;
    logic [26:0]         small_reg, small_next;
    logic [7:0]          ebig_reg, ebig_next;
    logic                sgn_reg, sgn_next;
    logic                sub_reg, sub_next;
    logic [27:0]         sum_reg, sum_next;
    logic [31:0]         acc_reg, acc_next;
    logic                m_valid_reg, m_valid_next;
    logic [15:0]         m_dot_result_reg, m_dot_result_next;

    qbdp_pkg::half_t     cur_act;
    logic                cur_wneg;
    logic [7:0]          cur_wmag;
    qbdp_pkg::bk_state_t fin_state;

    // term rounding
    logic [4:0]  t_lz;
    logic [28:0] t_norm;
    logic        t_up;
    logic [24:0] t_rnd;
    logic [7:0]  t_exp_c;
    logic [23:0] t_mant_c;
    logic        t_any_inf;
    logic        t_nan_c;

    // accumulator unpack and alignment
    logic        a_sign;
    logic [7:0]  a_ef;
    logic [22:0] a_man;
    logic        a_zero;
    logic        a_inf;
    logic        a_nan;
    logic [7:0]  a_exp;
    logic [23:0] a_mant;
    logic        is_special;
    logic [31:0] special_val;
    logic        acc_big;
    logic [23:0] s_m;
    logic [7:0]  b_e;
    logic [7:0]  s_e;
    logic [7:0]  d;
    logic [4:0]  dc;
    logic [54:0] sh_full;

    // post-add normalize and round
    logic [4:0]  n_lz;
    logic [26:0] n_m;
    logic [9:0]  n_e;
    logic        n_up;
    logic [24:0] n_rnd;
    logic [9:0]  n_e2;
    logic [23:0] n_mant;
    logic [31:0] n_val;

    assign cur_act  = term_sel_reg ? item_reg.act2 : item_reg.act1;
    assign cur_wneg = term_sel_reg ? item_reg.w2_neg : item_reg.w1_neg;
    assign cur_wmag = term_sel_reg ? item_reg.w2_mag : item_reg.w1_mag;

    assign fin_state = (item_reg.two_terms && !term_sel_reg) ? qbdp_pkg::BK_MUL1
                     : (item_reg.last ? qbdp_pkg::BK_EMIT : qbdp_pkg::BK_IDLE);

    always_comb begin
        t_lz      = qbdp_pkg::lzc29(mterm_reg);
        t_norm    = mterm_reg << t_lz;
        t_up      = t_norm[4] & ((|t_norm[3:0]) | t_norm[5]);
        t_rnd     = {1'b0, t_norm[28:5]} + 25'(t_up);
        t_exp_c   = 8'({4'd0, cur_act.exp} + {4'd0, item_reg.scale.exp} + 9'd105
                       - {4'd0, t_lz} + 9'(t_rnd[24]));
        t_mant_c  = t_rnd[24] ? t_rnd[24:1] : t_rnd[23:0];
        t_any_inf = cur_act.inf | item_reg.scale.inf;
        t_nan_c   = cur_act.nan | item_reg.scale.nan
                  | (t_any_inf & (cur_act.zero | item_reg.scale.zero | (cur_wmag == 8'd0)));
    end

    always_comb begin
        a_sign = acc_reg[31];
        a_ef   = acc_reg[30:23];
        a_man  = acc_reg[22:0];
        a_zero = (a_ef == 8'd0) && (a_man == 23'd0);
        a_inf  = (a_ef == 8'hFF) && (a_man == 23'd0);
        a_nan  = (a_ef == 8'hFF) && (a_man != 23'd0);
        a_exp  = (a_ef == 8'd0) ? 8'd1 : a_ef;
        a_mant = {(a_ef != 8'd0), a_man};

        is_special = a_nan | a_inf | t_nan_reg | t_inf_reg | t_zero_reg | a_zero;
        if (a_nan || t_nan_reg || (a_inf && t_inf_reg && (a_sign != t_sign_reg))) begin
            special_val = qbdp_pkg::SINGLE_QNAN;
        end else if (a_inf) begin
            special_val = acc_reg;
        end else if (t_inf_reg) begin
            special_val = {t_sign_reg, 8'hFF, 23'd0};
        end else if (t_zero_reg) begin
            special_val = a_zero ? {a_sign & t_sign_reg, 31'd0} : acc_reg;
        end else begin
            special_val = {t_sign_reg, t_exp_reg, t_mant_reg[22:0]};
        end

        acc_big = (a_exp > t_exp_reg) || ((a_exp == t_exp_reg) && (a_mant >= t_mant_reg));
        s_m     = acc_big ? t_mant_reg : a_mant;
        b_e     = acc_big ? a_exp : t_exp_reg;
        s_e     = acc_big ? t_exp_reg : a_exp;
        d       = b_e - s_e;
        dc      = (d > 8'd28) ? 5'd28 : d[4:0];
        sh_full = {s_m, 3'b000, 28'd0} >> dc;
    end

    always_comb begin
        n_lz   = qbdp_pkg::lzc29({sum_reg[26:0], 2'b00});
        if (sum_reg[27]) begin
            n_m = {sum_reg[27:2], sum_reg[1] | sum_reg[0]};
            n_e = {2'd0, ebig_reg} + 10'd1;
        end else begin
            n_m = sum_reg[26:0] << n_lz;
            n_e = {2'd0, ebig_reg} - {5'd0, n_lz};
        end
        n_up   = n_m[2] & (n_m[1] | n_m[0] | n_m[3]);
        n_rnd  = {1'b0, n_m[26:3]} + 25'(n_up);
        n_e2   = n_e + 10'(n_rnd[24]);
        n_mant = n_rnd[24] ? n_rnd[24:1] : n_rnd[23:0];
        if (sum_reg == 28'd0) begin
            n_val = 32'd0;
        end else if (n_e2 >= 10'd255) begin
            n_val = {sgn_reg, 8'hFF, 23'd0};
        end else begin
            n_val = {sgn_reg, n_e2[7:0], n_mant[22:0]};
        end
    end

    always_comb begin
        state_next        = state_reg;
        item_next         = item_reg;
        term_sel_next     = term_sel_reg;
        p1_next           = p1_reg;
        mterm_next        = mterm_reg;
        t_sign_next       = t_sign_reg;
        t_exp_next        = t_exp_reg;
        t_mant_next       = t_mant_reg;
        t_zero_next       = t_zero_reg;
        t_inf_next        = t_inf_reg;
        t_nan_next        = t_nan_reg;
        big_next          = big_reg;
        small_next        = small_reg;
        ebig_next         = ebig_reg;
        sgn_next          = sgn_reg;
        sub_next          = sub_reg;
        sum_next          = sum_reg;
        acc_next          = acc_reg;
        m_dot_result_next = m_dot_result_reg;
        m_valid_next      = m_valid_reg && !m_ready;
        q_ready           = 1'b0;

        case (state_reg)
            qbdp_pkg::BK_IDLE: begin
                q_ready = 1'b1;
                if (q_valid) begin
                    item_next     = q_item;
                    term_sel_next = 1'b0;
                    state_next    = qbdp_pkg::BK_MUL1;
                end
            end
            qbdp_pkg::BK_MUL1: begin
                p1_next    = cur_act.mant * item_reg.scale.mant;
                state_next = qbdp_pkg::BK_MUL2;
            end
            qbdp_pkg::BK_MUL2: begin
                mterm_next = 29'({7'd0, p1_reg} * {21'd0, cur_wmag});
                state_next = qbdp_pkg::BK_TERM;
            end
            qbdp_pkg::BK_TERM: begin
                t_sign_next = cur_act.sign ^ item_reg.scale.sign ^ cur_wneg;
                t_exp_next  = t_exp_c;
                t_mant_next = t_mant_c;
                t_nan_next  = t_nan_c;
                t_inf_next  = t_any_inf & ~t_nan_c;
                t_zero_next = (mterm_reg == 29'd0);
                state_next  = qbdp_pkg::BK_ALIGN;
            end
            qbdp_pkg::BK_ALIGN: begin
                if (is_special) begin
                    acc_next      = special_val;
                    term_sel_next = 1'b1;
                    state_next    = fin_state;
                end else begin
                    big_next   = {acc_big ? a_mant : t_mant_reg, 3'b000};
                    small_next = sh_full[54:28] | {26'd0, |sh_full[27:0]};
                    ebig_next  = b_e;
                    sgn_next   = acc_big ? a_sign : t_sign_reg;
                    sub_next   = (a_sign != t_sign_reg);
                    state_next = qbdp_pkg::BK_ADD;
                end
            end
            qbdp_pkg::BK_ADD: begin
                sum_next   = sub_reg ? ({1'b0, big_reg} - {1'b0, small_reg})
                                     : ({1'b0, big_reg} + {1'b0, small_reg});
                state_next = qbdp_pkg::BK_NORM;
            end
            qbdp_pkg::BK_NORM: begin
                acc_next      = n_val;
                term_sel_next = 1'b1;
                state_next    = fin_state;
            end
            qbdp_pkg::BK_EMIT: begin
                // hold until the output register frees up
                if (!m_valid_reg || m_ready) begin
                    m_valid_next      = 1'b1;
                    m_dot_result_next = qbdp_pkg::to_half(acc_reg);
                    acc_next          = 32'd0;
                    state_next        = qbdp_pkg::BK_IDLE;
                end
            end
            default: begin
                state_next = qbdp_pkg::BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= qbdp_pkg::BK_IDLE;
            acc_reg     <= 32'd0;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            acc_reg     <= acc_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        item_reg         <= item_next;
        term_sel_reg     <= term_sel_next;
        p1_reg           <= p1_next;
        mterm_reg        <= mterm_next;
        t_sign_reg       <= t_sign_next;
        t_exp_reg        <= t_exp_next;
        t_mant_reg       <= t_mant_next;
        t_zero_reg       <= t_zero_next;
        t_inf_reg        <= t_inf_next;
        t_nan_reg        <= t_nan_next;
        big_reg          <= big_next;
        small_reg        <= small_next;
        ebig_reg         <= ebig_next;
        sgn_reg          <= sgn_next;
        sub_reg          <= sub_next;
        sum_reg          <= sum_next;
        m_dot_result_reg <= m_dot_result_next;
    end

    assign m_valid      = m_valid_reg;
    assign m_dot_result = m_dot_result_reg;

endmodule

FILE: rtl/core/quantized_block_dot_product.sv
// An accepted end beat reaches m_valid once its terms are summed: two per beat in 4-bit mode,
// one in 8-bit mode; a term that meets a zero, infinity or NaN skips add and normalize.
// A new beat is taken only when the datapath is idle; an end beat also passes the emit step. Each
// term walks multiply, multiply, round, align, add, normalize on one shared float datapath.
// A two-entry queue lets the input side run ahead; a held result stalls the datapath.
// Reset (aresetn, synchronous, low): sum to +0, weight_format to 4-bit, queue and output emptied.
module quantized_block_dot_product (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic        cfg_weight_format,
    input  logic        s_valid,
    output logic        s_ready,
    input  logic [15:0] s_act_first,
    input  logic [15:0] s_act_second,
    input  logic [7:0]  s_weight_code,
    input  logic [15:0] s_block_scale,
    input  logic        s_end_of_dot,
    output logic        m_valid,
    input  logic        m_ready,
    output logic [15:0] m_dot_result
);

    logic            push_valid;
    logic            push_ready;
    qbdp_pkg::item_t push_item;
    logic            pop_valid;
    logic            pop_ready;
    qbdp_pkg::item_t pop_item;

    qbdp_front u_front (
        .aclk              (aclk),
        .aresetn           (aresetn),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_weight_format (cfg_weight_format),
        .s_valid           (s_valid),
        .s_ready           (s_ready),
        .s_act_first       (s_act_first),
        .s_act_second      (s_act_second),
        .s_weight_code     (s_weight_code),
        .s_block_scale     (s_block_scale),
        .s_end_of_dot      (s_end_of_dot),
        .push_valid        (push_valid),
        .push_ready        (push_ready),
        .push_item         (push_item)
    );

    qbdp_fifo u_fifo (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push_valid (push_valid),
        .push_ready (push_ready),
        .push_item  (push_item),
        .pop_valid  (pop_valid),
        .pop_ready  (pop_ready),
        .pop_item   (pop_item)
    );

    qbdp_back u_back (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .q_valid      (pop_valid),
        .q_ready      (pop_ready),
        .q_item       (pop_item),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_dot_result (m_dot_result)
    );

endmodule
